// ----- hw/rtl/gics_pkg.sv -----
`timescale 1ns / 1ps

package gics_pkg;

    localparam int MAX_SIDE_DEFAULT    = 64;
    localparam int WEIGHT_BITS_DEFAULT = 16;

    localparam int CELL_INDEX_BITS = 12;
    localparam int DRAW_BITS       = 16;
    localparam int COORD_BITS      = 32;
    localparam int STEP_BITS       = 31;
    localparam int SIDE_REG_BITS   = 7;
    localparam int DENSITY_BITS    = 16;
    localparam int CFG_DATA_BITS   = 32;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int DIVIDEND_BITS   = 33;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_BUILD  = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_OUTSIDE   = 2'd2;
    localparam logic [1:0] STATUS_WRITE_OUT = 2'd3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_X    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_Y    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_SIZE   = 3'd4;

    typedef struct packed {
        logic                     start;
        logic [DIVIDEND_BITS-1:0] dividend;
        logic [STEP_BITS-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic [DIVIDEND_BITS-1:0] quotient;
        logic [STEP_BITS-1:0]     remainder;
    } div_rsp_t;

endpackage

// ----- hw/rtl/gics_div.sv -----
`timescale 1ns / 1ps

module gics_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  gics_pkg::div_req_t req,
    output gics_pkg::div_rsp_t rsp
);

    localparam int DW = gics_pkg::DIVIDEND_BITS;
    localparam int VW = gics_pkg::STEP_BITS;
    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [VW:0]   trial;
    logic [VW+1:0] diff;

    always_comb begin
        trial = {rem_reg, quo_reg[DW-1]};
        diff  = {1'b0, trial} - {2'b00, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                cnt_reg <= CW'(DW);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (cnt_reg != '0) begin
            if (!diff[VW+1]) begin
                rem_reg <= diff[VW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_reg <= trial[VW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ----- hw/rtl/grid_inverse_cdf_sampler.sv -----
`timescale 1ns / 1ps

// Channel  | Direction | Payload
// s_       | in        | tuser: operation; tdata: request fields
// m_       | out       | tuser: status; tdata: result fields
// cfg_     | in        | register index and write data
//
// A build reads and sums every cell in use, and a sample runs a binary search over
// the running-sum memory and then one pass of the shared divider. A density query
// makes up to two divider passes. After reset the weight memory is cleared one cell
// per cycle, all MAX_SIDE*MAX_SIDE cells, with s_tready low. A stalled result waits
// in the output register; the next request is taken once the result has been loaded
// there.

module grid_inverse_cdf_sampler #(
    parameter int MAX_SIDE    = gics_pkg::MAX_SIDE_DEFAULT,
    parameter int WEIGHT_BITS = gics_pkg::WEIGHT_BITS_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cell_index[11:0], weight[27:12], uniform_draw[43:28], query_x[75:44],
    // query_y[107:76]
    input  logic [111:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // sample_x[31:0], sample_y[63:32], chosen_cell[75:64], density[91:76]
    output logic [95:0]  m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [gics_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [gics_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

    localparam int CELLS     = MAX_SIDE * MAX_SIDE;
    localparam int CELL_BITS = $clog2(CELLS);
    localparam int SIDE_BITS = $clog2(MAX_SIDE) + 1;
    localparam int SUM_BITS  = WEIGHT_BITS + CELL_BITS;
    localparam int DRAW_BITS = gics_pkg::DRAW_BITS;
    localparam int CMP_BITS  = SUM_BITS + DRAW_BITS;

    typedef enum logic [17:0] {
        ST_CLEAR     = 18'h00001,
        ST_IDLE      = 18'h00002,
        ST_BUILD_RD  = 18'h00004,
        ST_BUILD_ACC = 18'h00008,
        ST_SRCH_RD   = 18'h00010,
        ST_SRCH_CMP  = 18'h00020,
        ST_SDIV_GO   = 18'h00040,
        ST_SDIV_WAIT = 18'h00080,
        ST_SMUL_X    = 18'h00100,
        ST_SMUL_Y    = 18'h00200,
        ST_SADD      = 18'h00400,
        ST_QDX_GO    = 18'h00800,
        ST_QDX_WAIT  = 18'h01000,
        ST_QDY_GO    = 18'h02000,
        ST_QDY_WAIT  = 18'h04000,
        ST_QREAD     = 18'h08000,
        ST_QDATA     = 18'h10000,
        ST_DONE      = 18'h20000
    } state_t;

    state_t state_reg, state_next;

    logic [gics_pkg::SIDE_REG_BITS-1:0] width_reg, height_reg;
    logic [31:0] origin_x_reg, origin_y_reg;
    logic [gics_pkg::STEP_BITS-1:0] step_reg;
    logic built_reg, built_next;
    logic [SUM_BITS-1:0] total_reg, total_next;

    logic [WEIGHT_BITS-1:0] weight_mem [CELLS];
    logic [SUM_BITS-1:0]    sum_mem [CELLS];
    logic [WEIGHT_BITS-1:0] weight_rdata;
    logic [SUM_BITS-1:0]    sum_rdata;
    logic                   weight_we;
    logic [CELL_BITS-1:0]   weight_waddr, weight_raddr;
    logic [WEIGHT_BITS-1:0] weight_wdata;
    logic                   sum_we;

    logic [CELL_BITS:0]   clr_reg, clr_next;
    logic [CELL_BITS:0]   idx_reg, idx_next;
    logic [SUM_BITS-1:0]  acc_reg, acc_next;
    logic [CELL_BITS-1:0] lo_reg, lo_next, hi_reg, hi_next, mid;
    logic [CELL_BITS:0]   mid_sum;
    logic [CMP_BITS-1:0]  target_reg, target_next;
    logic [31:0]          prod_reg, prod_next;
    logic [31:0]          qx_reg, qx_next, qy_reg, qy_next;
    logic [SIDE_BITS-1:0] ix_reg, ix_next, iy_reg, iy_next;
    logic [CELL_BITS-1:0] ci_reg, ci_next;

    logic [31:0] res_sx_reg, res_sx_next, res_sy_reg, res_sy_next;
    logic [11:0] res_cell_reg, res_cell_next;
    logic [15:0] res_dens_reg, res_dens_next;
    logic [1:0]  res_status_reg, res_status_next;

    logic        out_valid_reg;
    logic [95:0] out_data_reg;
    logic [1:0]  out_user_reg;

    logic [SIDE_BITS-1:0]   side_w, side_h;
    logic [2*SIDE_BITS-1:0] cells_used;
    logic [31:0] cells_used32, ci_in32, last32;
    logic [gics_pkg::STEP_BITS-1:0] step_eff;
    logic [32:0] dx, dy;
    logic [31:0] quo_low;
    logic        quo_big;
    logic        load_out;

    gics_pkg::div_req_t div_req;
    gics_pkg::div_rsp_t div_rsp;

    gics_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        if (width_reg == '0) begin
            side_w = SIDE_BITS'(1);
        end else if (32'(width_reg) > 32'(MAX_SIDE)) begin
            side_w = SIDE_BITS'(MAX_SIDE);
        end else begin
            side_w = SIDE_BITS'(width_reg);
        end
        if (height_reg == '0) begin
            side_h = SIDE_BITS'(1);
        end else if (32'(height_reg) > 32'(MAX_SIDE)) begin
            side_h = SIDE_BITS'(MAX_SIDE);
        end else begin
            side_h = SIDE_BITS'(height_reg);
        end
        cells_used   = side_w * side_h;
        cells_used32 = 32'(cells_used);
        last32       = cells_used32 - 32'd1;
        ci_in32      = 32'(s_tdata[11:0]);
        step_eff     = (step_reg == '0) ? gics_pkg::STEP_BITS'(1) : step_reg;
        mid_sum      = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid          = mid_sum[CELL_BITS:1];
        dx           = {qx_reg[31], qx_reg} - {origin_x_reg[31], origin_x_reg};
        dy           = {qy_reg[31], qy_reg} - {origin_y_reg[31], origin_y_reg};
        quo_low      = div_rsp.quotient[31:0];
        quo_big      = div_rsp.quotient[32];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= gics_pkg::SIDE_REG_BITS'(64);
            height_reg   <= gics_pkg::SIDE_REG_BITS'(64);
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            step_reg     <= gics_pkg::STEP_BITS'(65536);
        end else if (cfg_we) begin
            unique case (cfg_index)
                gics_pkg::CFG_GRID_WIDTH:  width_reg    <= cfg_wdata[6:0];
                gics_pkg::CFG_GRID_HEIGHT: height_reg   <= cfg_wdata[6:0];
                gics_pkg::CFG_ORIGIN_X:    origin_x_reg <= cfg_wdata;
                gics_pkg::CFG_ORIGIN_Y:    origin_y_reg <= cfg_wdata;
                gics_pkg::CFG_STEP_SIZE:   step_reg     <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next      = state_reg;
        built_next      = built_reg;
        total_next      = total_reg;
        clr_next        = clr_reg;
        idx_next        = idx_reg;
        acc_next        = acc_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        target_next     = target_reg;
        prod_next       = prod_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        ix_next         = ix_reg;
        iy_next         = iy_reg;
        ci_next         = ci_reg;
        res_sx_next     = res_sx_reg;
        res_sy_next     = res_sy_reg;
        res_cell_next   = res_cell_reg;
        res_status_next = res_status_reg;
        weight_we       = 1'b0;
        weight_waddr    = clr_reg[CELL_BITS-1:0];
        weight_wdata    = '0;
        weight_raddr    = idx_reg[CELL_BITS-1:0];
        sum_we          = 1'b0;
        div_req         = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                weight_we = 1'b1;
                clr_next  = clr_reg + 1'b1;
                if (32'(clr_reg) == 32'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                res_sx_next     = '0;
                res_sy_next     = '0;
                res_cell_next   = '0;
                res_status_next = gics_pkg::STATUS_OK;
                qx_next         = s_tdata[75:44];
                qy_next         = s_tdata[107:76];
                idx_next        = '0;
                acc_next        = '0;
                lo_next         = '0;
                hi_next         = last32[CELL_BITS-1:0];
                target_next     = CMP_BITS'(s_tdata[43:28]) * CMP_BITS'(total_reg);
                if (s_tvalid) begin
                    unique case (s_tuser)
                        gics_pkg::OP_WRITE: begin
                            state_next = ST_DONE;
                            if (ci_in32 >= cells_used32) begin
                                res_status_next = gics_pkg::STATUS_WRITE_OUT;
                            end else begin
                                weight_we    = 1'b1;
                                weight_waddr = ci_in32[CELL_BITS-1:0];
                                weight_wdata = WEIGHT_BITS'(s_tdata[27:12]);
                                built_next   = 1'b0;
                            end
                        end
                        gics_pkg::OP_BUILD: begin
                            state_next = ST_BUILD_RD;
                        end
                        gics_pkg::OP_SAMPLE: begin
                            if (!built_reg || total_reg == '0) begin
                                res_status_next = gics_pkg::STATUS_EMPTY;
                                state_next      = ST_DONE;
                            end else if (last32 == 32'd0) begin
                                state_next = ST_SDIV_GO;
                            end else begin
                                state_next = ST_SRCH_RD;
                            end
                        end
                        gics_pkg::OP_QUERY: begin
                            state_next = ST_QDX_GO;
                        end
                        default: ;
                    endcase
                end
            end
            ST_BUILD_RD: begin
                weight_raddr = idx_reg[CELL_BITS-1:0];
                state_next   = ST_BUILD_ACC;
            end
            ST_BUILD_ACC: begin
                acc_next = acc_reg + SUM_BITS'(weight_rdata);
                sum_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (32'(idx_reg) == last32) begin
                    total_next      = acc_next;
                    built_next      = 1'b1;
                    res_status_next = (acc_next == '0) ? gics_pkg::STATUS_EMPTY
                                                       : gics_pkg::STATUS_OK;
                    state_next      = ST_DONE;
                end else begin
                    state_next = ST_BUILD_RD;
                end
            end
            ST_SRCH_RD: begin
                state_next = ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
                if ({sum_rdata, {DRAW_BITS{1'b0}}} > target_reg) begin
                    hi_next = mid;
                end else begin
                    lo_next = mid + 1'b1;
                end
                state_next = (lo_next < hi_next) ? ST_SRCH_RD : ST_SDIV_GO;
            end
            ST_SDIV_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = gics_pkg::DIVIDEND_BITS'(lo_reg);
                div_req.divisor  = gics_pkg::STEP_BITS'(side_w);
                res_cell_next    = 12'(lo_reg);
                state_next       = ST_SDIV_WAIT;
            end
            ST_SDIV_WAIT: begin
                if (div_rsp.done) begin
                    ix_next    = div_rsp.remainder[SIDE_BITS-1:0];
                    iy_next    = quo_low[SIDE_BITS-1:0];
                    state_next = ST_SMUL_X;
                end
            end
            ST_SMUL_X: begin
                prod_next  = 32'(ix_reg) * 32'(step_eff);
                state_next = ST_SMUL_Y;
            end
            ST_SMUL_Y: begin
                res_sx_next = prod_reg + origin_x_reg;
                prod_next   = 32'(iy_reg) * 32'(step_eff);
                state_next  = ST_SADD;
            end
            ST_SADD: begin
                res_sy_next = prod_reg + origin_y_reg;
                state_next  = ST_DONE;
            end
            ST_QDX_GO: begin
                if (dx[32]) begin
                    res_status_next = gics_pkg::STATUS_OUTSIDE;
                    state_next      = ST_DONE;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = dx;
                    div_req.divisor  = step_eff;
                    state_next       = ST_QDX_WAIT;
                end
            end
            ST_QDX_WAIT: begin
                if (div_rsp.done) begin
                    if (quo_big || quo_low >= 32'(side_w)) begin
                        res_status_next = gics_pkg::STATUS_OUTSIDE;
                        state_next      = ST_DONE;
                    end else begin
                        ix_next    = quo_low[SIDE_BITS-1:0];
                        state_next = ST_QDY_GO;
                    end
                end
            end
            ST_QDY_GO: begin
                if (dy[32]) begin
                    res_status_next = gics_pkg::STATUS_OUTSIDE;
                    state_next      = ST_DONE;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = dy;
                    div_req.divisor  = step_eff;
                    state_next       = ST_QDY_WAIT;
                end
            end
            ST_QDY_WAIT: begin
                if (div_rsp.done) begin
                    if (quo_big || quo_low >= 32'(side_h)) begin
                        res_status_next = gics_pkg::STATUS_OUTSIDE;
                        state_next      = ST_DONE;
                    end else begin
                        iy_next    = quo_low[SIDE_BITS-1:0];
                        state_next = ST_QREAD;
                    end
                end
            end
            ST_QREAD: begin
                ci_next      = CELL_BITS'(32'(ix_reg) + 32'(iy_reg) * 32'(side_w));
                weight_raddr = ci_next;
                state_next   = ST_QDATA;
            end
            ST_QDATA: begin
                weight_raddr  = ci_reg;
                state_next    = ST_DONE;
                res_cell_next = 12'(ci_reg);
            end
            ST_DONE: begin
                weight_raddr = ci_reg;
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (weight_we) begin
            weight_mem[weight_waddr] <= weight_wdata;
        end
        weight_rdata <= weight_mem[weight_raddr];
    end

    always_ff @(posedge aclk) begin
        if (sum_we) begin
            sum_mem[idx_reg[CELL_BITS-1:0]] <= acc_next;
        end
        sum_rdata <= sum_mem[mid];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            built_reg     <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            total_reg <= total_next;
            if (cfg_we && (cfg_index == gics_pkg::CFG_GRID_WIDTH ||
                           cfg_index == gics_pkg::CFG_GRID_HEIGHT)) begin
                built_reg <= 1'b0;
            end else begin
                built_reg <= built_next;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        acc_reg        <= acc_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        target_reg     <= target_next;
        prod_reg       <= prod_next;
        qx_reg         <= qx_next;
        qy_reg         <= qy_next;
        ix_reg         <= ix_next;
        iy_reg         <= iy_next;
        ci_reg         <= ci_next;
        res_sx_reg     <= res_sx_next;
        res_sy_reg     <= res_sy_next;
        res_cell_reg   <= res_cell_next;
        res_status_reg <= res_status_next;
        res_dens_reg   <= res_dens_next;
        if (load_out) begin
            out_data_reg <= {4'b0000, res_dens_reg, res_cell_reg, res_sy_reg, res_sx_reg};
            out_user_reg <= res_status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb begin
        res_dens_next = res_dens_reg;
        if (state_reg == ST_IDLE) begin
            res_dens_next = '0;
        end else if (state_reg == ST_QDATA) begin
            res_dens_next = 16'(weight_rdata);
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while the previous one is still in progress");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_tready && !m_tvalid)
        else $error("block active during the weight clearing pass");

    assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_SDIV_WAIT || state_reg == ST_QDX_WAIT ||
                         state_reg == ST_QDY_WAIT)
        else $error("divider finished outside a wait state");

endmodule
